// ===== rtl/core/ivr3d_pkg.sv =====
`default_nettype none
package ivr3d_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;
  localparam int MAX_BANDS   = 4096;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int BAND_W = $clog2(MAX_BANDS);

  // Size registers hold the largest value itself, one bit more than a coordinate.
  localparam int CSZ_W = COL_W + 1;
  localparam int RSZ_W = ROW_W + 1;
  localparam int BSZ_W = BAND_W + 1;

  localparam int PLANE_MAX   = MAX_COLUMNS * MAX_ROWS;
  localparam int VALUE_DEPTH = PLANE_MAX + MAX_COLUMNS + 1;
  localparam int PLANE_W     = $clog2(PLANE_MAX + 1);
  localparam int RING_W      = $clog2(VALUE_DEPTH);
  localparam int LAG_W       = $clog2(VALUE_DEPTH + 1);
  localparam int CNT_W       = $clog2(PLANE_MAX * MAX_BANDS + 1);
  localparam int ADDR_A_W    = ROW_W + COL_W;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_COLUMNS   = 2'd1,
    CFG_ROWS      = 2'd2,
    CFG_BANDS     = 2'd3
  } cfg_index_t;

endpackage
`default_nettype wire

// ===== rtl/core/isolated_voxel_removal_3d.sv =====
`default_nettype none
// Isolated voxel removal over a 3x3x3 neighborhood, streamed in raster order
// (column fastest, then row, then band), signed Q16.16 voxels.
//
// Input channel (in_valid/in_ready): one request carries a voxel or a flush.
// After the last voxel, flush requests drain the remaining outputs, one each.
// Output channel (out_valid/out_ready): one request per emitted voxel, with
// out_last high on the final voxel of the volume.
// Throughput: one request per cycle in both directions. An accepted request
// enters the stage one registers, then the output register. The synchronous reads
// of the mark planes, the row buffer and the value delay ring happen at the
// accepting edge, and the following cycle counts the marks and picks the value.
// An output voxel is produced columns*rows + columns + 1 voxels after its
// own input; the value ring holds exactly that many entries.
// When the receiver stalls, the whole two-stage pipeline holds and in_ready
// drops; the output register parts the two channels.
// Reset clears all counters and needs no clearing pass; the stores hold
// stale contents that only feed boundary voxels. Reset and every write to
// the configuration port hold in_ready low while the derived plane size,
// lag and volume size settle through their registers.
// Write configuration only while the block is idle.
module isolated_voxel_removal_3d (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [ivr3d_pkg::DATA_W-1:0] cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [31:0]           voxel_value,
  input  wire                          is_flush,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [31:0]           out_value,
  output logic                         out_last
);
  import ivr3d_pkg::*;

  // Configuration registers.
  logic signed [31:0] threshold;
  logic [7:0]         num_columns;
  logic [7:0]         num_rows;
  logic [12:0]        num_bands;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= '0;
      num_columns <= 8'd128;
      num_rows    <= 8'd128;
      num_bands   <= 13'd64;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD: threshold   <= cfg_data;
        CFG_COLUMNS:   num_columns <= cfg_data[7:0];
        CFG_ROWS:      num_rows    <= cfg_data[7:0];
        CFG_BANDS:     num_bands   <= cfg_data[12:0];
        default:       threshold   <= threshold;
      endcase
    end
  end

  // Sizes saturated to their ranges, zero counting as one.
  logic [CSZ_W-1:0] c_eff;
  logic [RSZ_W-1:0] r_eff;
  logic [BSZ_W-1:0] b_eff;

  always_comb begin
    if (num_columns == 8'd0) c_eff = CSZ_W'(1);
    else if (32'(num_columns) > MAX_COLUMNS) c_eff = CSZ_W'(MAX_COLUMNS);
    else c_eff = CSZ_W'(num_columns);
    if (num_rows == 8'd0) r_eff = RSZ_W'(1);
    else if (32'(num_rows) > MAX_ROWS) r_eff = RSZ_W'(MAX_ROWS);
    else r_eff = RSZ_W'(num_rows);
    if (num_bands == 13'd0) b_eff = BSZ_W'(1);
    else if (32'(num_bands) > MAX_BANDS) b_eff = BSZ_W'(MAX_BANDS);
    else b_eff = BSZ_W'(num_bands);
  end

  // Derived sizes, one multiplier per register stage.
  logic [PLANE_W-1:0] plane_q;
  logic [LAG_W-1:0]   lag_q;
  logic [CNT_W-1:0]   total_q;
  logic [1:0]         settle;

  always_ff @(posedge clk) begin
    plane_q <= PLANE_W'(c_eff * r_eff);
    lag_q   <= LAG_W'(plane_q) + LAG_W'(c_eff) + LAG_W'(1);
    total_q <= CNT_W'(plane_q * b_eff);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= 2'd3;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Pipeline control: everything moves when the output register is free.
  logic advance;
  logic accept;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && (settle == 2'd0);
  assign accept   = in_valid && in_ready;

  // Input side counters.
  logic [COL_W-1:0]  input_column;
  logic [ROW_W-1:0]  input_row;
  logic [BAND_W-1:0] input_band;
  logic [CNT_W-1:0]  received;
  logic [CNT_W-1:0]  emitted_count;
  logic              input_done;
  logic [RING_W-1:0] ring_ptr;
  logic [RING_W-1:0] rd_ptr;

  logic              new_volume;
  logic [COL_W-1:0]  col0, col_next;
  logic [ROW_W-1:0]  row0, row_next;
  logic [BAND_W-1:0] band0, band_next;
  logic [CNT_W-1:0]  recv0, received_next;
  logic [CNT_W-1:0]  emit0, emitted_next;
  logic              done0, input_done_next;
  logic [RING_W-1:0] ptr0, ring_ptr_next;
  logic [RING_W-1:0] rdp0, rd_ptr_next;
  logic              take_voxel;
  logic              emit;
  logic              mark;
  logic              interior;

  always_comb begin
    new_volume = emitted_count >= total_q;
    col0  = new_volume ? '0 : input_column;
    row0  = new_volume ? '0 : input_row;
    band0 = new_volume ? '0 : input_band;
    recv0 = new_volume ? '0 : received;
    emit0 = new_volume ? '0 : emitted_count;
    done0 = new_volume ? 1'b0 : input_done;
    ptr0  = new_volume ? '0 : ring_ptr;
    rdp0  = new_volume ? '0 : rd_ptr;

    take_voxel      = !is_flush && !done0;
    col_next        = col0;
    row_next        = row0;
    band_next       = band0;
    received_next   = recv0;
    input_done_next = done0;
    if (take_voxel) begin
      received_next = recv0 + CNT_W'(1);
      if (CSZ_W'(col0) + CSZ_W'(1) >= c_eff) begin
        col_next = '0;
        if (RSZ_W'(row0) + RSZ_W'(1) >= r_eff) begin
          row_next = '0;
          if (BSZ_W'(band0) + BSZ_W'(1) >= b_eff) begin
            band_next       = '0;
            input_done_next = 1'b1;
          end else begin
            band_next = band0 + BAND_W'(1);
          end
        end else begin
          row_next = row0 + ROW_W'(1);
        end
      end else begin
        col_next = col0 + COL_W'(1);
      end
    end

    emit = (emit0 < total_q) &&
           (input_done_next ||
            ({1'b0, received_next} >=
             {1'b0, emit0} + (CNT_W + 1)'(lag_q) + (CNT_W + 1)'(1)));
    emitted_next = emit0 + CNT_W'(emit);

    // Write and read sides of the value ring advance on their own, so a
    // volume shorter than the lag still reads its first voxel back first.
    if (take_voxel && ({1'b0, ptr0} + (RING_W + 1)'(1) >= (RING_W + 1)'(lag_q)))
      ring_ptr_next = '0;
    else if (take_voxel)
      ring_ptr_next = ptr0 + RING_W'(1);
    else
      ring_ptr_next = ptr0;

    if (emit && ({1'b0, rdp0} + (RING_W + 1)'(1) >= (RING_W + 1)'(lag_q)))
      rd_ptr_next = '0;
    else if (emit)
      rd_ptr_next = rdp0 + RING_W'(1);
    else
      rd_ptr_next = rdp0;

    mark = voxel_value > threshold;
    // The window centered lag voxels back is interior exactly when the
    // newest voxel lies at column, row and band two or beyond.
    interior = (32'(col0) >= 32'd2) && (32'(row0) >= 32'd2) && (32'(band0) >= 32'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      input_band    <= '0;
      received      <= '0;
      emitted_count <= '0;
      input_done    <= 1'b0;
      ring_ptr      <= '0;
      rd_ptr        <= '0;
    end else if (accept) begin
      input_column  <= col_next;
      input_row     <= row_next;
      input_band    <= band_next;
      received      <= received_next;
      emitted_count <= emitted_next;
      input_done    <= input_done_next;
      ring_ptr      <= ring_ptr_next;
      rd_ptr        <= rd_ptr_next;
    end
  end

  // Stores. Mark plane: per row and column, marks of this band and the one
  // before. Row buffer: per column, the two newest rows of the 3x3 column
  // of marks over rows and bands. Value ring: the output delay line.
  logic [1:0]        mark_plane [PLANE_MAX];
  logic [5:0]        row_buf    [MAX_COLUMNS];
  logic [31:0]       value_ring [VALUE_DEPTH];

  logic [ADDR_A_W-1:0] addr_a;
  assign addr_a = {row0, col0};

  // Stage one registers.
  logic              s1_voxel;
  logic              s1_emit;
  logic              s1_mark;
  logic              s1_interior;
  logic              s1_last;
  logic [ADDR_A_W-1:0] s1_addr_a;
  logic [COL_W-1:0]  s1_col;
  logic [1:0]        rd_a;
  logic [5:0]        rd_b;
  logic [31:0]       rd_value;
  logic              fwd_a;
  logic              fwd_b;
  logic [1:0]        fwd_a_data;
  logic [5:0]        fwd_b_data;
  logic [8:0]        win1;
  logic [8:0]        win2;

  logic [1:0]  a_eff;
  logic [5:0]  b_eff_rd;
  logic [1:0]  wr_a;
  logic [5:0]  wr_b;
  logic [8:0]  stack;
  logic [26:0] window;
  logic        isolated;
  logic        s1_write;

  always_comb begin
    a_eff    = fwd_a ? fwd_a_data : rd_a;
    b_eff_rd = fwd_b ? fwd_b_data : rd_b;
    wr_a     = {s1_mark, a_eff[1]};
    wr_b     = {s1_mark, a_eff, b_eff_rd[5:3]};
    stack    = {s1_mark, a_eff, b_eff_rd};
    window   = {stack, win1, win2};
    // Fewer than two marks: no bit or exactly one bit set.
    isolated = (window & (window - 27'd1)) == 27'd0;
    s1_write = advance && s1_voxel;
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      mark_plane[s1_addr_a] <= wr_a;
      row_buf[s1_col]       <= wr_b;
    end
    if (accept) begin
      rd_a       <= mark_plane[addr_a];
      rd_b       <= row_buf[col0];
      fwd_a      <= s1_write && (s1_addr_a == addr_a);
      fwd_b      <= s1_write && (s1_col == col0);
      fwd_a_data <= wr_a;
      fwd_b_data <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rd_value <= value_ring[rdp0];
    end
    if (accept && take_voxel) begin
      value_ring[ptr0] <= voxel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_voxel <= 1'b0;
      s1_emit  <= 1'b0;
    end else if (advance) begin
      s1_voxel <= accept && take_voxel;
      s1_emit  <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mark     <= mark;
      s1_interior <= interior;
      s1_last     <= (emit0 + CNT_W'(1)) == total_q;
      s1_addr_a   <= addr_a;
      s1_col      <= col0;
    end
    if (s1_write) begin
      win1 <= stack;
      win2 <= win1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      out_value <= (s1_voxel && s1_interior && isolated) ? 32'sd0 : rd_value;
      out_last  <= s1_last;
    end
  end

  // An interior window is always completed by a voxel that also emits.
  a_interior_emits: assert property (@(posedge clk) disable iff (rst)
    (s1_voxel && s1_interior) |-> s1_emit)
    else $error("interior voxel without an output");

  // A configuration write closes the input for the settling time.
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input open right after a configuration write");

  // The output count never passes the volume size while sizes are settled.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (settle == 2'd0 && !$past(cfg_we)) |-> (emitted_count <= total_q))
    else $error("more outputs than voxels in the volume");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ivr3d_pkg::*;

  localparam int MARK_DEPTH  = 2 * VALUE_DEPTH + 1;
  localparam int CYCLE_LIMIT = 3000000;

  // Ports of the block under test.
  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [DATA_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] voxel_value;
  logic               is_flush;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic               out_last;

  isolated_voxel_removal_3d dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .voxel_value(voxel_value),
    .is_flush(is_flush), .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_last(out_last)
  );

  // One cleaned voxel as the output channel should present it.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } cleaned_voxel_t;

  cleaned_voxel_t cleaned_queue[$];

  // Local copy of the configuration and of the streaming state.
  logic signed [31:0] mark_level;
  logic [7:0]         cols_reg;
  logic [7:0]         rows_reg;
  logic [12:0]        bands_reg;
  logic [31:0]        value_ring[VALUE_DEPTH];
  bit                 mark_ring[MARK_DEPTH];
  longint             in_col, in_row, in_band, sent_out;
  bit                 in_complete;

  int  error_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_request;
  int  hold_left;
  longint cycle_count;

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_size(longint v, longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint vol_columns();
    return clamp_size(cols_reg, MAX_COLUMNS);
  endfunction

  function automatic longint vol_rows();
    return clamp_size(rows_reg, MAX_ROWS);
  endfunction

  function automatic longint vol_bands();
    return clamp_size(bands_reg, MAX_BANDS);
  endfunction

  function automatic longint vol_total();
    return vol_columns() * vol_rows() * vol_bands();
  endfunction

  // Advances the local model by one accepted request and queues the cleaned
  // voxel that request releases, if any.
  task automatic predict_cleaned(input logic signed [31:0] v, input logic flush);
    longint ncol, nrow, nband, plane, total, lag, received, e;
    longint c, t, r, b, pos;
    int count;
    bit interior;
    cleaned_voxel_t res;
    begin
      ncol = vol_columns();
      nrow = vol_rows();
      nband = vol_bands();
      plane = ncol * nrow;
      total = plane * nband;
      lag = plane + ncol + 1;
      // A finished volume restarts everything on the next request.
      if (sent_out >= total) begin
        in_col = 0;
        in_row = 0;
        in_band = 0;
        sent_out = 0;
        in_complete = 0;
      end
      received = (in_band * nrow + in_row) * ncol + in_col;
      if (in_complete || received >= total) begin
        in_complete = 1;
        received = total;
      end
      if (!flush && !in_complete) begin
        value_ring[received % VALUE_DEPTH] = v;
        mark_ring[received % MARK_DEPTH] = (v > mark_level);
        received++;
        in_col++;
        if (in_col >= ncol) begin
          in_col = 0;
          in_row++;
          if (in_row >= nrow) begin
            in_row = 0;
            in_band++;
            if (in_band >= nband) begin
              in_band = 0;
              in_complete = 1;
            end
          end
        end
      end
      e = sent_out;
      if (e < total && (in_complete || received >= e + lag + 1)) begin
        c = e % ncol;
        t = e / ncol;
        r = t % nrow;
        b = t / nrow;
        res.value = value_ring[e % VALUE_DEPTH];
        interior = ncol >= 3 && nrow >= 3 && nband >= 3 && c >= 1 && c + 2 <= ncol &&
                   r >= 1 && r + 2 <= nrow && b >= 1 && b + 2 <= nband;
        if (interior) begin
          count = 0;
          for (int db = -1; db <= 1; db++)
            for (int dr = -1; dr <= 1; dr++)
              for (int dc = -1; dc <= 1; dc++) begin
                pos = e + db * plane + dr * ncol + dc;
                if (pos >= 0 && mark_ring[pos % MARK_DEPTH]) count++;
              end
          // Fewer than two marks in the neighborhood means an isolated voxel.
          if (count < 2) res.value = '0;
        end
        res.last = (e + 1 == total);
        cleaned_queue.push_back(res);
        sent_out = e + 1;
      end
    end
  endtask

  // Writes all four registers on consecutive cycles, keeping the enable high
  // throughout so it is assigned only once per time step.
  task automatic write_registers(input logic signed [31:0] level, input logic [7:0] cols,
                                 input logic [7:0] rows, input logic [12:0] bands);
    begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_THRESHOLD;
      cfg_data <= level;
      @(negedge clk);
      cfg_index <= CFG_COLUMNS;
      cfg_data <= {24'd0, cols};
      @(negedge clk);
      cfg_index <= CFG_ROWS;
      cfg_data <= {24'd0, rows};
      @(negedge clk);
      cfg_index <= CFG_BANDS;
      cfg_data <= {19'd0, bands};
      @(negedge clk);
      cfg_we <= 1'b0;
      mark_level = level;
      cols_reg = cols;
      rows_reg = rows;
      bands_reg = bands;
    end
  endtask

  // Offers one request and returns at the falling edge after it is accepted.
  // Valid is left high so back-to-back requests need no extra assignment.
  task automatic send_request(input logic signed [31:0] v, input logic flush);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      voxel_value <= v;
      is_flush <= flush;
      do @(posedge clk); while (!in_ready);
      predict_cleaned(v, flush);
      @(negedge clk);
    end
  endtask

  // Draws a voxel value that lands above or at/below the mark level, with some
  // fully random values mixed in so every bit toggles.
  function automatic logic signed [31:0] pick_voxel(int mark_pct);
    longint lvl, span;
    bit [63:0] r;
    begin
      lvl = mark_level;
      r = {$urandom, $urandom};
      if ($urandom_range(99) < 15) return $urandom;
      if ($urandom_range(99) < mark_pct) begin
        if (lvl >= 64'sd2147483647) return $urandom;
        span = 64'sd2147483647 - lvl;
        return 32'(lvl + 1 + longint'(r >> 1) % span);
      end
      if (lvl <= -64'sd2147483648) return $urandom;
      span = lvl + 64'sd2147483648 + 1;
      return 32'(-64'sd2147483648 + longint'(r >> 1) % span);
    end
  endfunction

  // Streams one whole volume, then drains it. Noise adds early flushes, which
  // change nothing, and dropped voxels among the draining requests.
  task automatic stream_volume(input int mark_pct, input int noise_pct);
    begin
      while (!in_complete) begin
        if ($urandom_range(99) < noise_pct) send_request($urandom, 1'b1);
        else send_request(pick_voxel(mark_pct), 1'b0);
      end
      while (sent_out < vol_total()) begin
        if ($urandom_range(99) < noise_pct) send_request($urandom, 1'b0);
        else send_request($urandom, 1'b1);
      end
      in_valid <= 1'b0;
    end
  endtask

  // Sender pause: waits for every expected voxel, then sends one flush that
  // opens the next volume, and lets it settle so registers may be written.
  task automatic close_volume();
    begin
      @(negedge clk);
      while (cleaned_queue.size() != 0) @(negedge clk);
      send_request($urandom, 1'b1);
      in_valid <= 1'b0;
      repeat (10) @(negedge clk);
    end
  endtask

  task automatic test_directed();
    logic signed [31:0] v;
    begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_registers(32'sd0, 8'd4, 8'd4, 13'd4);
      // A flush at the very start of a volume yields nothing.
      send_request(32'sd0, 1'b1);
      // Extremes of the value field, one interior mark and one marked pair.
      for (int i = 0; i < 64; i++) begin
        case (i)
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -32'sd1;
          3: v = 32'sd1;
          21: v = 32'sh0001_0000;
          42, 43: v = 32'sh0002_0000;
          default: v = (i % 5 == 0) ? -32'sd7 : 32'sd0;
        endcase
        send_request(v, 1'b0);
      end
      // A voxel past the end of the volume is dropped but still drains.
      send_request(32'sh1234_5678, 1'b0);
      stream_volume(0, 0);
      close_volume();
    end
  endtask

  task automatic test_size_extremes();
    begin
      send_idle_pct = 15;
      recv_stall_pct = 15;
      // Zero columns counts as one, so nothing is interior.
      write_registers(32'sh8000_0000, 8'd0, 8'd2, 13'd3);
      stream_volume(50, 10);
      close_volume();
      // Oversized columns saturate and a band count of zero counts as one;
      // the whole volume is shorter than the output lag.
      write_registers(32'sh8000_0000, 8'd255, 8'd1, 13'd0);
      stream_volume(50, 5);
      close_volume();
      // Highest threshold: nothing is ever marked.
      write_registers(32'sh7fff_ffff, 8'd4, 8'd3, 13'd3);
      stream_volume(50, 5);
      close_volume();
    end
  endtask

  task automatic test_random_volumes();
    logic signed [31:0] level;
    begin
      for (int phase = 0; phase < 4; phase++) begin
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        case ($urandom_range(3))
          0: level = $urandom;
          1: level = 32'sd0;
          2: level = $urandom_range(65535) << 8;
          default: level = -$signed(32'($urandom_range(65535)));
        endcase
        write_registers(level, 8'($urandom_range(5, 3)), 8'($urandom_range(4, 3)),
                        13'($urandom_range(4, 3)));
        stream_volume($urandom_range(40, 3), $urandom_range(100) < 30 ? 8 : 0);
        close_volume();
      end
    end
  endtask

  task automatic test_backpressure();
    begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_registers(32'sd0, 8'd5, 8'd4, 13'd4);
      // A long receiver hold-off while the sender keeps offering requests.
      hold_request = 300;
      stream_volume(15, 0);
      close_volume();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compares every accepted output request with the oldest expected voxel.
  always @(posedge clk) begin
    cleaned_voxel_t exp_voxel;
    if (!rst && out_valid && out_ready) begin
      if (cleaned_queue.size() == 0) begin
        $error("unexpected output request: out_value %0d out_last %0d",
               out_value, out_last);
        error_count++;
      end else begin
        exp_voxel = cleaned_queue.pop_front();
        if (out_value !== exp_voxel.value) begin
          $error("out_value: expected %0d, actual %0d", exp_voxel.value, out_value);
          error_count++;
        end
        if (out_last !== exp_voxel.last) begin
          $error("out_last: expected %0d, actual %0d", exp_voxel.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    voxel_value = '0;
    is_flush = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    cycle_count = 0;
    // Local model starts from the reset state of the block.
    mark_level = 32'sd0;
    cols_reg = 8'd128;
    rows_reg = 8'd128;
    bands_reg = 13'd64;
    in_col = 0;
    in_row = 0;
    in_band = 0;
    sent_out = 0;
    in_complete = 0;
    foreach (value_ring[i]) value_ring[i] = '0;
    foreach (mark_ring[i]) mark_ring[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_size_extremes();
    test_random_volumes();
    test_backpressure();

    // Every expectation must have arrived; the last volume was already closed.
    recv_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (error_count == 0 && cleaned_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (cleaned_queue.size() != 0)
        $error("%0d expected voxels never arrived", cleaned_queue.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
